>>> design/u2d_pkg.sv
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CountW = 16;

  localparam logic [UnitW-1:0] CapacityReset = 16'd255;

  // lead byte class boundaries, overlong limit and end-of-string byte
  localparam logic [7:0] LeadTwoMin   = 8'hC2;
  localparam logic [7:0] LeadThreeMin = 8'hE0;
  localparam logic [7:0] LeadThreeE1  = 8'hE1;
  localparam logic [7:0] LeadFourMin  = 8'hF0;
  localparam logic [7:0] OverlongMin  = 8'hA0;
  localparam logic [7:0] NulByte      = 8'h00;

  // continuation bytes still expected
  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendTwo  = 2'd2;

  typedef struct packed {
    logic [1:0]        pending;
    logic [ByteW-1:0]  lead;
    logic [5:0]        first_cont;
    logic [CountW-1:0] count;
  } state_t;

  typedef struct packed {
    logic [UnitW-1:0]  code_unit;
    logic              is_end;
    logic [CountW-1:0] unit_count;
  } result_t;

endpackage

`default_nettype wire

>>> design/u2d_decode.sv
// ----------------------------------------------------------------------------
// u2d_decode
// Per-byte decode step: next sequence state and the optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_decode (
  input  var u2d_pkg::state_t             state_i,
  input  var logic [u2d_pkg::ByteW-1:0]   byte_i,
  input  var logic [u2d_pkg::CountW-1:0]  capacity_i,
  output u2d_pkg::state_t                 state_o,
  output logic                            res_valid_o,
  output u2d_pkg::result_t                res_o
);

  logic                     is_cont;
  logic                     handled;
  logic                     want_emit;
  logic [u2d_pkg::UnitW-1:0] unit;

  assign is_cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    state_o   = state_i;
    handled   = 1'b0;
    want_emit = 1'b0;
    unit      = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_i == u2d_pkg::NulByte) begin
      // end of string: drop any partial sequence, report the count
      state_o.pending  = u2d_pkg::PendNone;
      state_o.count    = '0;
      res_valid_o      = 1'b1;
      res_o.is_end     = 1'b1;
      res_o.unit_count = state_i.count;
    end else begin
      state_o.pending = u2d_pkg::PendNone;
      if (state_i.pending == u2d_pkg::PendOne || state_i.pending == u2d_pkg::PendTwo) begin
        if (state_i.lead < u2d_pkg::LeadThreeMin) begin
          if (is_cont) begin
            handled   = 1'b1;
            want_emit = 1'b1;
            unit      = {5'd0, state_i.lead[4:0], byte_i[5:0]};
          end
        end else if (state_i.pending == u2d_pkg::PendTwo) begin
          // E0 needs A0..BF next, otherwise the form is overlong
          if (is_cont && (state_i.lead >= u2d_pkg::LeadThreeE1 ||
                          byte_i >= u2d_pkg::OverlongMin)) begin
            handled            = 1'b1;
            state_o.first_cont = byte_i[5:0];
            state_o.pending    = u2d_pkg::PendOne;
          end
        end else begin
          if (is_cont) begin
            handled   = 1'b1;
            want_emit = 1'b1;
            unit      = {state_i.lead[3:0], state_i.first_cont, byte_i[5:0]};
          end
        end
      end

      // failed or absent sequence: treat the byte as a fresh lead
      if (!handled) begin
        if (byte_i[7] == 1'b0) begin
          want_emit = 1'b1;
          unit      = {8'd0, byte_i};
        end else if (byte_i >= u2d_pkg::LeadTwoMin && byte_i < u2d_pkg::LeadThreeMin) begin
          state_o.lead    = byte_i;
          state_o.pending = u2d_pkg::PendOne;
        end else if (byte_i >= u2d_pkg::LeadThreeMin && byte_i < u2d_pkg::LeadFourMin) begin
          state_o.lead    = byte_i;
          state_o.pending = u2d_pkg::PendTwo;
        end
      end

      // capacity reached: keep decoding, suppress the unit
      if (want_emit && (state_i.count < capacity_i)) begin
        state_o.count   = state_i.count + 16'd1;
        res_valid_o     = 1'b1;
        res_o.code_unit = unit;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/utf8_to_ucs2_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_top
// UTF-8 byte stream in, UCS-2 code units and end-of-string counts out.
// ----------------------------------------------------------------------------
// Path: an accepted byte is staged in the input register (byte_q), and its result, if any,
//   is then loaded into the result register (res_q), which can stall on out_ready_i.
// Throughput: one byte per cycle while the result register is free or being drained;
//   the decode step between the two registers is combinational compare and merge logic.
// Reset: clears both valid flags and the sequence state; capacity returns to 255.
`default_nettype none

module utf8_to_ucs2_stream_decoder_top (
  input  var logic                          clk_i,
  input  var logic                          rst_ni,
  input  var logic                          cfg_valid_i,
  output logic                              cfg_ready_o,
  input  var logic [u2d_pkg::CountW-1:0]    cfg_capacity_units_i,
  input  var logic                          in_valid_i,
  output logic                              in_ready_o,
  input  var logic [u2d_pkg::ByteW-1:0]     in_byte_i,
  output logic                              out_valid_o,
  input  var logic                          out_ready_i,
  output logic [u2d_pkg::UnitW-1:0]         code_unit_o,
  output logic                              is_end_o,
  output logic [u2d_pkg::CountW-1:0]        unit_count_o
);

  logic [u2d_pkg::CountW-1:0] capacity_q;
  logic                       in_valid_q;
  logic [u2d_pkg::ByteW-1:0]  byte_q;
  u2d_pkg::state_t            state_q, state_d;
  logic                       out_valid_q;
  u2d_pkg::result_t           res_q;
  logic                       res_valid;
  u2d_pkg::result_t           res_d;
  logic                       advance;
  logic                       out_load;

  assign cfg_ready_o = 1'b1;

  // the staged byte moves on whenever the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign out_load   = advance && res_valid;

  u2d_decode u_decode (
    .state_i     (state_q),
    .byte_i      (byte_q),
    .capacity_i  (capacity_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= u2d_pkg::CapacityReset;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_capacity_units_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = res_q.code_unit;
  assign is_end_o     = res_q.is_end;
  assign unit_count_o = res_q.unit_count;

  // an end-of-string item always restarts the count
  a_end_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && res_d.is_end |=> state_q.count == '0)
    else $error("count not cleared after end of string");

  // end items carry no unit, unit items carry no count
  a_end_unit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_end_o |-> code_unit_o == '0)
    else $error("end item with nonzero code unit");

  a_unit_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_end_o |-> unit_count_o == '0)
    else $error("unit item with nonzero count");

  // a unit item moves the count up by exactly one
  a_unit_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !res_d.is_end |=> state_q.count == $past(state_q.count) + 16'd1)
    else $error("count did not advance with a unit");

endmodule

`default_nettype wire
